@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

@@ hdl/mhf_pkg.sv @@
// ----------------------------------------------------------------------------
// Multicast hash filter package
// Shared types, constants and the reflected CRC-32 byte step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mhf_pkg;

  localparam int GRP_W      = 32;
  localparam int GRP_USED_W = 23;
  localparam int HASH_W     = 6;
  localparam int FILTER_W   = 64;
  localparam int HALF_W     = 32;
  localparam int OUT_DATA_W = 72;
  localparam int CRC_W      = 32;
  localparam int MAC_BYTES  = 6;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  localparam logic [7:0] MAC_OUI0 = 8'h01;
  localparam logic [7:0] MAC_OUI1 = 8'h00;
  localparam logic [7:0] MAC_OUI2 = 8'h5E;

  typedef enum logic {
    OP_JOIN  = 1'b0,
    OP_LEAVE = 1'b1
  } opcode_t;

  typedef logic [HASH_W-1:0]   hash_idx_t;
  typedef logic [FILTER_W-1:0] filter_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc_in,
                                                input logic [7:0]       data);
    logic [CRC_W-1:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

@@ hdl/mhf_hash.sv @@
// ----------------------------------------------------------------------------
// Multicast hash index
// Builds the 01:00:5E group MAC and folds it through CRC-32 to a filter index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mhf_hash (
  input  logic [mhf_pkg::GRP_USED_W-1:0] grp_low,
  output mhf_pkg::hash_idx_t             hash_index
);
  import mhf_pkg::*;

  logic [7:0]       mac [MAC_BYTES];
  logic [CRC_W-1:0] crc_chain [MAC_BYTES+1];

  assign mac[0] = MAC_OUI0;
  assign mac[1] = MAC_OUI1;
  assign mac[2] = MAC_OUI2;
  assign mac[3] = {1'b0, grp_low[22:16]};
  assign mac[4] = grp_low[15:8];
  assign mac[5] = grp_low[7:0];

  assign crc_chain[0] = CRC_INIT;

  for (genvar i = 0; i < MAC_BYTES; i++) begin : g_byte
    assign crc_chain[i+1] = crc_byte(crc_chain[i], mac[i]);
  end

  assign hash_index = crc_chain[MAC_BYTES][CRC_W-1 -: HASH_W];

endmodule

@@ hdl/multicast_hash_filter_update_top.sv @@
// ----------------------------------------------------------------------------
// Multicast hash filter update
// Join/leave requests update a 64-bit CRC-32 hash filter with collision marks.
// ----------------------------------------------------------------------------
// One request is taken every cycle while the output is not stalled. The input
// register takes the request at the accepting edge; the CRC tree and the
// filter read-modify-write then feed the result register, which loads once
// the output is free. Filter and collision marks update as the result
// register loads, so back-to-back requests always see each other's effect.
// A stalled output holds the input register, and the stall reaches in_tready
// in the same cycle.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module multicast_hash_filter_update_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [mhf_pkg::GRP_W-1:0]       in_tdata,   // [31:0] group_address
  input  logic                            in_tuser,   // [0] opcode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [mhf_pkg::OUT_DATA_W-1:0]  out_tdata   // [5:0] hash_index,
                                                      // [6] was_collision,
                                                      // [38:7] filter_low,
                                                      // [70:39] filter_high,
                                                      // [71] zero
);
  import mhf_pkg::*;

  logic                  s1_valid_r;
  opcode_t               s1_op_r;
  logic [GRP_USED_W-1:0] s1_grp_r;
  logic                  s1_advance;
  logic                  s1_fire;
  logic                  in_fire;

  hash_idx_t             s1_index;
  filter_t               sel_bit;
  filter_t               filter_r, filter_nxt;
  filter_t               marks_r, marks_nxt;
  logic                  coll_nxt;

  logic                  out_valid_r;
  hash_idx_t             out_index_r;
  logic                  out_coll_r;

  assign s1_advance = !out_valid_r || out_tready;
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_fire    = in_tvalid && in_tready;
  assign s1_fire    = s1_valid_r && s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r  <= opcode_t'(in_tuser);
      s1_grp_r <= in_tdata[GRP_USED_W-1:0];
    end
  end

  mhf_hash u_hash (
    .grp_low    (s1_grp_r),
    .hash_index (s1_index)
  );

  assign sel_bit = filter_t'(1) << s1_index;

  always_comb begin
    filter_nxt = filter_r;
    marks_nxt  = marks_r;
    coll_nxt   = 1'b0;
    case (s1_op_r)
      OP_JOIN: begin
        if ((filter_r & sel_bit) != '0) begin
          marks_nxt = marks_r | sel_bit;
          coll_nxt  = 1'b1;
        end else begin
          filter_nxt = filter_r | sel_bit;
        end
      end
      OP_LEAVE: begin
        filter_nxt = filter_r & (~sel_bit | marks_r);
      end
      default: begin
        filter_nxt = filter_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r    <= '0;
      marks_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        filter_r <= filter_nxt;
        marks_r  <= marks_nxt;
      end
      if (s1_advance) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_index_r <= s1_index;
      out_coll_r  <= coll_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, filter_r[FILTER_W-1:HALF_W], filter_r[HALF_W-1:0],
                       out_coll_r, out_index_r};

  `ASSERT_SAME(a_marks_within_filter, clk, rst_n, 1'b1, (marks_r & ~filter_r) == '0)
  `ASSERT_NEXT(a_marks_sticky, clk, rst_n, 1'b1, (marks_r & $past(marks_r)) == $past(marks_r))
  `ASSERT_SAME(a_coll_bit_marked, clk, rst_n, out_valid_r && out_coll_r, filter_r[out_index_r] && marks_r[out_index_r])
  `ASSERT_NEXT(a_stall_holds_state, clk, rst_n, out_valid_r && !out_tready, $stable(filter_r) && $stable(marks_r))

endmodule
